// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// No dependencies; compiled out when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ===== sv/tlvhp_pkg.sv =====
// Shared types and constants for the TLV header parser.
// No dependencies.
package tlvhp_pkg;

   localparam logic [7:0] MARK_TWO   = 8'd253;
   localparam logic [7:0] MARK_FOUR  = 8'd254;
   localparam logic [7:0] MARK_EIGHT = 8'd255;

   localparam logic [2:0] EXT_TWO_BYTES  = 3'd2;
   localparam logic [2:0] EXT_FOUR_BYTES = 3'd4;

   localparam logic [3:0] COUNT_MAX = 4'd15;
   localparam logic [3:0] HDR_MAX   = 4'd10;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_TRUNC = 2'd1,
      ST_UNSUP = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      PH_TYPE_FIRST = 4'b0001,
      PH_TYPE_EXT   = 4'b0010,
      PH_LEN_FIRST  = 4'b0100,
      PH_LEN_EXT    = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  bytes_left;
      logic [31:0] accumulator;
      logic [31:0] saved_type;
      logic [3:0]  consumed;
   } state_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] tlv_type;
      logic [31:0] value_length;
      logic [3:0]  header_bytes;
   } result_type;

   localparam state_type STATE_IDLE = '{
      phase:       PH_TYPE_FIRST,
      bytes_left:  3'd0,
      accumulator: 32'd0,
      saved_type:  32'd0,
      consumed:    4'd0
   };

endpackage

// ===== sv/tlvhp_req_if.sv =====
// Byte input channel of the TLV header parser: valid/ready plus payload.
// No dependencies.
interface tlvhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ===== sv/tlvhp_rsp_if.sv =====
// Result channel of the TLV header parser: valid/ready plus decoded header.
// No dependencies.
interface tlvhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] tlv_type;
   logic [31:0] value_length;
   logic [3:0]  header_bytes;

   modport source (output valid, output status, output tlv_type, output value_length,
                   output header_bytes, input ready);
   modport sink   (input valid, input status, input tlv_type, input value_length,
                   input header_bytes, output ready);
endinterface

// ===== sv/tlvhp_step.sv =====
// Per-byte decode step: current parser state and one byte in, next state
// and an optional result out. Depends on tlvhp_pkg.
module tlvhp_step (
   input  tlvhp_pkg::state_type  state,
   input  logic [7:0]            data_byte,
   input  logic                  end_of_buffer,
   output tlvhp_pkg::state_type  state_next,
   output logic                  result_valid,
   output tlvhp_pkg::result_type result
);
   import tlvhp_pkg::*;

   logic [3:0]  count;
   logic [31:0] shifted;
   logic [2:0]  left_dec;
   logic [31:0] done_value;
   logic        number_done;
   logic        in_type;

   assign count    = (state.consumed < COUNT_MAX) ? state.consumed + 4'd1 : state.consumed;
   assign shifted  = {state.accumulator[23:0], data_byte};
   assign left_dec = (state.bytes_left != 3'd0) ? state.bytes_left - 3'd1 : 3'd0;
   assign in_type  = (state.phase == PH_TYPE_FIRST) || (state.phase == PH_TYPE_EXT);

   always_comb begin
      state_next          = state;
      state_next.consumed = count;
      result_valid        = 1'b0;
      result              = '{status: ST_OK, tlv_type: 32'd0, value_length: 32'd0,
                              header_bytes: count};
      number_done         = 1'b0;
      done_value          = shifted;

      unique case (state.phase)
         PH_TYPE_FIRST, PH_LEN_FIRST: begin
            if (data_byte < MARK_TWO) begin
               number_done = 1'b1;
               done_value  = {24'd0, data_byte};
            end else if (data_byte == MARK_EIGHT) begin
               result_valid  = 1'b1;
               result.status = ST_UNSUP;
            end else begin
               state_next.bytes_left  = (data_byte == MARK_TWO) ? EXT_TWO_BYTES
                                                                : EXT_FOUR_BYTES;
               state_next.accumulator = 32'd0;
               state_next.phase       = (state.phase == PH_TYPE_FIRST) ? PH_TYPE_EXT
                                                                       : PH_LEN_EXT;
               if (end_of_buffer) begin
                  result_valid  = 1'b1;
                  result.status = ST_TRUNC;
               end
            end
         end
         PH_TYPE_EXT, PH_LEN_EXT: begin
            state_next.accumulator = shifted;
            state_next.bytes_left  = left_dec;
            if (left_dec == 3'd0) begin
               number_done = 1'b1;
            end else if (end_of_buffer) begin
               result_valid  = 1'b1;
               result.status = ST_TRUNC;
            end
         end
         default: begin
            result_valid  = 1'b1;
            result.status = ST_TRUNC;
         end
      endcase

      if (number_done) begin
         if (in_type) begin
            // type complete: keep it, move on to the length number
            state_next.saved_type  = done_value;
            state_next.phase       = PH_LEN_FIRST;
            state_next.accumulator = 32'd0;
            state_next.bytes_left  = 3'd0;
            if (end_of_buffer) begin
               result_valid  = 1'b1;
               result.status = ST_TRUNC;
            end
         end else begin
            result_valid        = 1'b1;
            result.status       = ST_OK;
            result.tlv_type     = state.saved_type;
            result.value_length = done_value;
         end
      end

      if (result_valid) begin
         state_next = STATE_IDLE;
      end
   end

endmodule

// ===== sv/tlv_header_parser_core.sv =====
// TLV header parser top level: state registers, result register, handshakes.
// Depends on tlvhp_pkg, tlvhp_req_if, tlvhp_rsp_if, tlvhp_step, assert_macros.svh.
//
// Usage:
//   req_chan carries packet bytes, one per transfer, with end_of_buffer set
//   on the last byte available. rsp_chan carries one transfer per header:
//   status (ok, truncated, unsupported 8-byte marker), tlv_type,
//   value_length and header_bytes (1..10, counting the byte that ended it).
//   Bytes that do not end a header give no transfer on rsp_chan.
// Timing:
//   One byte per cycle while rsp_chan is not stalled. A byte is decoded in
//   the cycle it is taken; the result appears on rsp_chan in the next cycle.
//   The parser state updates on every input transfer, so back-to-back bytes
//   never stall while the result register is free or being drained.
// Stalls:
//   The result register holds while rsp_chan.ready is low; req_chan.ready
//   then drops until the pending result is taken (same cycle is fine).
// Reset:
//   reset (synchronous, active high) returns the parser to waiting for the
//   first type byte of a header and empties the result register.
module tlv_header_parser_core (
   input  logic               clock,
   input  logic               reset,
   tlvhp_req_if.sink          req_chan,
   tlvhp_rsp_if.source        rsp_chan
);
   import tlvhp_pkg::*;

   `include "assert_macros.svh"

   state_type  state_ff;
   state_type  state_in;
   state_type  step_next;
   result_type result_ff;
   result_type result_in;
   result_type step_result;
   logic       step_valid;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_fire;
   logic       out_free;

   // Output register is free when empty or draining this cycle.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = out_free;
   assign req_fire       = req_chan.valid && out_free;

   tlvhp_step u_step (
      .state         (state_ff),
      .data_byte     (req_chan.data_byte),
      .end_of_buffer (req_chan.end_of_buffer),
      .state_next    (step_next),
      .result_valid  (step_valid),
      .result        (step_result)
   );

   always_comb begin
      state_in     = req_fire ? step_next : state_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire && step_valid) begin
         result_in    = step_result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = result_ff.status;
   assign rsp_chan.tlv_type     = result_ff.tlv_type;
   assign rsp_chan.value_length = result_ff.value_length;
   assign rsp_chan.header_bytes = result_ff.header_bytes;

   // Header length is bounded: 1+4 type bytes plus 1+4 length bytes.
   `ASSERT_PROP(a_hdr_len, clock, reset,
      rsp_valid_ff |-> (result_ff.header_bytes != 4'd0 && result_ff.header_bytes <= HDR_MAX),
      "header_bytes out of range")
   // Error results carry zero numbers.
   `ASSERT_PROP(a_err_zero, clock, reset,
      (rsp_valid_ff && result_ff.status != ST_OK) |->
         (result_ff.tlv_type == 32'd0 && result_ff.value_length == 32'd0),
      "error result with nonzero fields")
   // Every emitted result returns the parser to idle.
   `ASSERT_PROP(a_idle_after, clock, reset,
      (req_fire && step_valid) |=>
         (state_ff.phase == PH_TYPE_FIRST && state_ff.consumed == 4'd0),
      "parser not idle after result")
   // A result is never overwritten before it is taken.
   `ASSERT_NEVER(a_no_overrun, clock, reset,
      req_fire && rsp_valid_ff && !rsp_chan.ready,
      "input accepted while result register full")

endmodule
